[rtl/dsi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsi_pkg: shared types, constants and sine table for the interpolated dds
// Holds the request codes, the queue entry layout and the sine lookup.
// ----------------------------------------------------------------------------
package dsi_pkg;

  // request codes on the func field
  localparam logic [1:0] FUNC_TICK   = 2'd0;
  localparam logic [1:0] FUNC_LOAD   = 2'd1;
  localparam logic [1:0] FUNC_TOGGLE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_LO_FREQ    = 2'd0;
  localparam logic [1:0] CFG_HI_FREQ    = 2'd1;
  localparam logic [1:0] CFG_FREQ_SPAN  = 2'd2;
  localparam logic [1:0] CFG_PHASE_GAIN = 2'd3;

  localparam int unsigned DSI_SAMPLE_BITS = 12;
  localparam int unsigned TABLE_DEPTH     = 256;
  localparam int unsigned TUNE_DIVISOR    = 600;
  localparam logic [11:0] MID_CODE        = 12'd2048;

  // reset values of the configuration registers
  localparam logic [15:0] LO_FREQ_RST    = 16'd200;
  localparam logic [15:0] HI_FREQ_RST    = 16'd2000;
  localparam logic [15:0] FREQ_SPAN_RST  = 16'd1800;
  localparam logic [15:0] PHASE_GAIN_RST = 16'd44695;

  // work classes handed from front to back
  typedef enum logic [1:0] {
    OP_TICK,
    OP_LOAD,
    OP_TOGGLE
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] upper;
  } q_item_t;

  // first quarter of the sine, amplitude 2047
  localparam logic [10:0] QUARTER_WAVE [65] = '{
    11'd0,    11'd50,   11'd100,  11'd151,  11'd201,  11'd251,  11'd300,  11'd350,
    11'd399,  11'd449,  11'd497,  11'd546,  11'd594,  11'd642,  11'd690,  11'd737,
    11'd783,  11'd830,  11'd875,  11'd920,  11'd965,  11'd1009, 11'd1052, 11'd1095,
    11'd1137, 11'd1179, 11'd1219, 11'd1259, 11'd1299, 11'd1337, 11'd1375, 11'd1411,
    11'd1447, 11'd1483, 11'd1517, 11'd1550, 11'd1582, 11'd1614, 11'd1644, 11'd1674,
    11'd1702, 11'd1729, 11'd1756, 11'd1781, 11'd1805, 11'd1828, 11'd1850, 11'd1871,
    11'd1891, 11'd1910, 11'd1927, 11'd1944, 11'd1959, 11'd1973, 11'd1986, 11'd1997,
    11'd2008, 11'd2017, 11'd2025, 11'd2032, 11'd2037, 11'd2041, 11'd2045, 11'd2046,
    11'd2047
  };

  // full-wave table entry built from the quarter wave
  function automatic logic [11:0] sine_entry(input logic [7:0] idx);
    logic [5:0]  k;
    logic [1:0]  quad;
    logic [10:0] q;
    k    = idx[5:0];
    quad = idx[7:6];
    if (quad[0]) begin
      q = QUARTER_WAVE[7'd64 - {1'b0, k}];
    end else begin
      q = QUARTER_WAVE[k];
    end
    if (quad[1]) begin
      return MID_CODE - {1'b0, q};
    end else begin
      return MID_CODE + {1'b0, q};
    end
  endfunction

endpackage
`default_nettype wire

[rtl/dsi_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsi_front: request intake and work queue
// Classifies each request, drops unused codes and holds up to two entries
// for the back end.
// ----------------------------------------------------------------------------
module dsi_front (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_stall,
  input  wire logic [1:0]     in_func,
  input  wire logic [31:0]    in_tuning_value,
  output logic                q_valid,
  output dsi_pkg::q_item_t    q_item,
  input  wire logic           q_pop
);
  import dsi_pkg::*;

  q_item_t    mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       accepted;
  logic       push;
  q_item_t    item;

  // classify the incoming request
  always_comb begin
    item.upper = in_tuning_value[31:16];
    item.op    = OP_TICK;
    push       = 1'b0;
    case (in_func)
      FUNC_TICK: begin
        item.op = OP_TICK;
        push    = accepted;
      end
      FUNC_LOAD: begin
        item.op = OP_LOAD;
        push    = accepted;
      end
      FUNC_TOGGLE: begin
        item.op = OP_TOGGLE;
        push    = accepted;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  assign in_stall = (count_r == 2'd2);
  assign accepted = in_valid && !in_stall;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // occupancy
  always_comb begin
    count_nxt = count_r;
    if (push && !q_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!push && q_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  // queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (q_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

[rtl/dsi_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dsi_back: oscillator execution engine
// Runs tuning loads (multiply, divide by 600, clamp, scale), audio toggles
// and sample ticks (phase step, table lookup, interpolation) one at a time.
// ----------------------------------------------------------------------------
module dsi_back #(
  parameter int unsigned SAMPLE_BITS = dsi_pkg::DSI_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   q_valid,
  input  wire dsi_pkg::q_item_t       q_item,
  output logic                        q_pop,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_dac_sample
);
  import dsi_pkg::*;

  localparam int unsigned SB    = SAMPLE_BITS;
  localparam int unsigned SHL   = (SB > 12) ? SB - 12 : 0;
  localparam int unsigned SHR   = (SB < 12) ? 12 - SB : 0;
  localparam logic [SB-1:0] MID = {1'b1, {(SB-1){1'b0}}};
  // ceil(2^36 / 75), exact for every dividend below 2^29
  localparam logic [29:0] RECIP_75 = 30'd916259690;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LD_DIV,
    ST_LD_CLAMP,
    ST_LD_STEP,
    ST_TK_RD,
    ST_TK_MUL,
    ST_TK_OUT
  } state_t;

  state_t              state_r;
  logic [15:0]         lo_freq_r;
  logic [15:0]         hi_freq_r;
  logic [15:0]         freq_span_r;
  logic [15:0]         phase_gain_r;
  logic [31:0]         phase_r;
  logic [31:0]         step_r;
  logic                audio_on_r;
  logic [31:0]         div_r;
  logic [22:0]         quo_r;
  logic [15:0]         freq_r;
  logic [SB-1:0]       a_r;
  logic [SB-1:0]       b_r;
  logic [7:0]          frac_r;
  logic signed [SB+9:0] prod_r;
  logic                out_valid_r;
  logic [SB-1:0]       sample_r;

  logic [58:0]         recip_prod;
  logic [23:0]         freq_sum;
  logic signed [SB:0]  diff;
  logic signed [SB+9:0] prod_nxt;
  logic signed [SB+9:0] interp;
  logic [SB-1:0]       sample_nxt;
  logic                out_free;

  // table value rescaled to the output width
  function automatic logic [SB-1:0] scale_code(input logic [11:0] v);
    logic [27:0] w;
    w = (28'(v) << SHL) >> SHR;
    return w[SB-1:0];
  endfunction

  // divide by 600: drop 3 bits, then multiply by the reciprocal of 75
  assign recip_prod = {30'd0, div_r[31:3]} * {29'd0, RECIP_75};

  // quotient stays below 2^23
  assign freq_sum = {8'd0, lo_freq_r} + {1'b0, quo_r};

  // interpolation arithmetic
  assign diff       = $signed({1'b0, b_r}) - $signed({1'b0, a_r});
  assign prod_nxt   = diff * $signed({1'b0, frac_r});
  assign interp     = $signed({10'd0, a_r}) + (prod_r >>> 8);
  assign sample_nxt = audio_on_r ? interp[SB-1:0] : MID;

  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = (state_r == ST_IDLE) && q_valid;
  assign out_valid      = out_valid_r;
  assign out_dac_sample = sample_r;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_freq_r    <= LO_FREQ_RST;
      hi_freq_r    <= HI_FREQ_RST;
      freq_span_r  <= FREQ_SPAN_RST;
      phase_gain_r <= PHASE_GAIN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LO_FREQ:    lo_freq_r    <= cfg_data;
        CFG_HI_FREQ:    hi_freq_r    <= cfg_data;
        CFG_FREQ_SPAN:  freq_span_r  <= cfg_data;
        CFG_PHASE_GAIN: phase_gain_r <= cfg_data;
        default:        lo_freq_r    <= lo_freq_r;
      endcase
    end
  end

  // sequencer, oscillator state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 32'd0;
      step_r      <= 32'd0;
      audio_on_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // sample taken and no new one loaded this cycle
      if (out_valid_r && !out_stall && (state_r != ST_TK_OUT)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (q_valid) begin
            case (q_item.op)
              OP_LOAD: begin
                div_r   <= q_item.upper * freq_span_r;
                state_r <= ST_LD_DIV;
              end
              OP_TOGGLE: begin
                audio_on_r <= !audio_on_r;
              end
              default: begin
                if (audio_on_r) begin
                  phase_r <= phase_r + step_r;
                end
                state_r <= ST_TK_RD;
              end
            endcase
          end
        end
        ST_LD_DIV: begin
          quo_r   <= recip_prod[58:36];
          state_r <= ST_LD_CLAMP;
        end
        ST_LD_CLAMP: begin
          if (freq_sum > {8'd0, hi_freq_r}) begin
            freq_r <= hi_freq_r;
          end else begin
            freq_r <= freq_sum[15:0];
          end
          state_r <= ST_LD_STEP;
        end
        ST_LD_STEP: begin
          step_r  <= freq_r * phase_gain_r;
          state_r <= ST_IDLE;
        end
        ST_TK_RD: begin
          a_r     <= scale_code(sine_entry(phase_r[31:24]));
          b_r     <= scale_code(sine_entry(phase_r[31:24] + 8'd1));
          frac_r  <= phase_r[23:16];
          state_r <= ST_TK_MUL;
        end
        ST_TK_MUL: begin
          prod_r  <= prod_nxt;
          state_r <= ST_TK_OUT;
        end
        ST_TK_OUT: begin
          if (out_free) begin
            sample_r    <= sample_nxt;
            out_valid_r <= 1'b1;
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

[rtl/dds_sine_interpolated_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// dds_sine_interpolated_unit: sine oscillator with table interpolation
// Phase accumulator, tuning-word frequency mapping and 12-bit DAC samples.
// ----------------------------------------------------------------------------
// usage
//   in_*  : requests with func (0 tick, 1 load tuning word, 2 toggle audio)
//           and the 32-bit tuning word; code 3 is accepted and dropped
//   out_* : one DAC sample per tick; the in and out channels take a
//           request on a clock edge with valid high and stall low
//   cfg_* : write enable, register index and 16-bit data; write only while
//           the block is idle
//   timing: requests go into a two-entry queue in front of a sequencer
//           that runs one request at a time; a tick passes from the queue
//           to the output register through a phase add, a table read, an
//           interpolation multiply and the output load, which waits while
//           a held sample stalls; a load runs a tuning multiply, a
//           reciprocal divide by 600, a clamp and a phase-gain multiply;
//           a toggle flips the audio enable as the request is taken
//   reset : phase, phase step and audio enable clear, registers return to
//           their defaults, the queue and the output empty
//   stall : a stalled sample holds in the output register; the sequencer
//           then waits at its next tick and the queue fills before in_stall
//           rises
// ----------------------------------------------------------------------------
module dds_sine_interpolated_unit #(
  parameter int unsigned SAMPLE_BITS = dsi_pkg::DSI_SAMPLE_BITS
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire logic [1:0]             in_func,
  input  wire logic [31:0]            in_tuning_value,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output logic [SAMPLE_BITS-1:0]      out_dac_sample,
  input  wire logic                   cfg_we,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [15:0]            cfg_data
);
  import dsi_pkg::*;

  logic    q_valid;
  q_item_t q_item;
  logic    q_pop;

  // intake and queue
  dsi_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_func         (in_func),
    .in_tuning_value (in_tuning_value),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop)
  );

  // execution
  dsi_back #(
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_dac_sample (out_dac_sample)
  );

endmodule
`default_nettype wire
